>>> hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Shared types and constants for the ARP cache with entry aging.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

  // Item actions; codes 6 and 7 are unused and do nothing
  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_LOOKUP = 3'd1,
    ACT_PACKET = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_FLUSH  = 3'd4,
    ACT_READ   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_FINISH
  } state_e;

  // One table slot as stored in memory
  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_MS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK = 2'd2;

  localparam logic [31:0] TTL_MS_RST      = 32'd120000;
  localparam logic [9:0]  MS_PER_TICK_RST = 10'd10;

  localparam logic [15:0] OPC_REQUEST = 16'd1;

endpackage

`default_nettype wire

>>> hw/rtl/arpc_req_if.sv
// ----------------------------------------------------------------------------
// ARP cache request channel
// Valid/ready channel carrying one action beat into the cache.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] ip_addr;
  logic [31:0] target_ip;
  logic [47:0] mac_addr;
  logic [15:0] arp_opcode;
  logic [3:0]  entry_index;

  modport source (
    output valid, action, ip_addr, target_ip, mac_addr, arp_opcode, entry_index,
    input  ready
  );

  modport sink (
    input  valid, action, ip_addr, target_ip, mac_addr, arp_opcode, entry_index,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/arpc_rsp_if.sv
// ----------------------------------------------------------------------------
// ARP cache response channel
// Valid/ready channel carrying one result beat out of the cache.
// ----------------------------------------------------------------------------
`default_nettype none

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] ip_out;
  logic [47:0] mac_out;
  logic [31:0] age_out;
  logic        send_reply;

  modport source (
    output valid, status, ip_out, mac_out, age_out, send_reply,
    input  ready
  );

  modport sink (
    input  valid, status, ip_out, mac_out, age_out, send_reply,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/arpc_store.sv
// ----------------------------------------------------------------------------
// ARP cache slot store
// Slot memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_store #(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned IW      = 4
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IW-1:0]    waddr_i,
  input  arpc_pkg::entry_t      wdata_i,
  input  wire logic             re_i,
  input  wire logic [IW-1:0]    raddr_i,
  output arpc_pkg::entry_t      rdata_o
);
  import arpc_pkg::*;

  entry_t mem_q [ENTRIES];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/arp_cache_with_aging_core.sv
// ----------------------------------------------------------------------------
// ARP cache with aging
// IPv4-to-MAC table with tick-based timestamps, expiry on lookup and learning
// from received ARP packets; one slot memory scanned by a small sequencer.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          beat
//   req      in   valid/ready        action, addresses, opcode, entry index
//   rsp      out  valid/ready        status, ip, mac, age, send_reply
//   cfg      in   cfg_we_i only      register index, 32-bit write data
//
// Tick, flush, unused actions and packets that learn nothing go from accept
// straight to the finish step, which registers the result beat.
// Lookup, delete, learning packets and read scan every slot, one memory read
// per cycle, then age one matched slot before the finish step; the next beat
// is taken only once the sequencer is back in idle.
// Reset clears all valid bits and the time counter and sets the registers to their reset values at once.
// A held result beat stalls the finish step; a new beat is taken while the
// previous result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_with_aging_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  arpc_req_if.sink                           req,
  arpc_rsp_if.source                         rsp,
  input  wire logic                          cfg_we_i,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                   cfg_wdata_i
);
  import arpc_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = (IW + 1 > 4) ? IW + 1 : 4;
  localparam logic [IW:0]   SCAN_END = (IW + 1)'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  // configuration
  logic [31:0] own_ip_q, ttl_q;
  logic [9:0]  mpt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= '0;
      ttl_q    <= TTL_MS_RST;
      mpt_q    <= MS_PER_TICK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN_IP:      own_ip_q <= cfg_wdata_i;
        CFG_TTL_MS:      ttl_q    <= cfg_wdata_i;
        CFG_MS_PER_TICK: mpt_q    <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e             state_q, state_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [31:0]        now_q, now_d;
  logic [IW:0]        scan_q, scan_d;
  logic               rd_vld_q, rd_vld_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               hit_q, hit_d;
  logic               free_fnd_q, free_fnd_d;
  logic               out_vld_q, out_vld_d;

  // datapath
  action_e       act_q, act_d;
  logic [31:0]   ip_q, ip_d, tgt_q, tgt_d;
  logic [47:0]   mac_q, mac_d;
  logic [15:0]   op_q, op_d;
  logic [3:0]    eidx_q, eidx_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, old_idx_q, old_idx_d;
  logic [31:0]   hit_ip_q, hit_ip_d, hit_stamp_q, hit_stamp_d, old_stamp_q, old_stamp_d;
  logic [47:0]   hit_mac_q, hit_mac_d;
  logic [31:0]   age_q, age_d;
  logic          status_q, status_d, reply_q, reply_d;
  logic [31:0]   ipo_q, ipo_d, ageo_q, ageo_d;
  logic [47:0]   maco_q, maco_d;

  // store ports
  logic          st_we, st_re;
  logic [IW-1:0] st_waddr;
  entry_t        st_wdata, st_rdata;

  arpc_store #(.ENTRIES(ENTRIES), .IW(IW)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (scan_q[IW-1:0]),
    .rdata_o (st_rdata)
  );

  logic        req_fire, out_free, fin_go, ent_v, sel_hit, learn_w, expired_w, found_w;
  logic [IW-1:0] lrn_idx;
  logic [41:0] prod_w;

  assign req_fire  = req.valid && req.ready;
  assign out_free  = !out_vld_q || rsp.ready;
  assign fin_go    = (state_q == ST_FINISH) && out_free;
  assign ent_v     = valid_q[rd_idx_q];
  assign sel_hit   = (act_q == ACT_READ) ? (ent_v && cnt_q == CW'(eidx_q))
                                         : (ent_v && st_rdata.ip == ip_q);
  assign learn_w   = (act_q == ACT_PACKET) && (ip_q != '0) && (tgt_q == own_ip_q);
  assign expired_w = hit_q && (act_q != ACT_READ) && (age_q > ttl_q);
  assign found_w   = hit_q && !expired_w;
  assign prod_w    = {10'd0, now_q - hit_stamp_q} * {32'd0, mpt_q};

  // pick the slot a learned sender goes to
  always_comb begin
    if (found_w) begin
      lrn_idx = hit_idx_q;
    end else if (hit_q) begin
      lrn_idx = (free_fnd_q && free_idx_q < hit_idx_q) ? free_idx_q : hit_idx_q;
    end else if (free_fnd_q) begin
      lrn_idx = free_idx_q;
    end else begin
      lrn_idx = old_idx_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          unique case (action_e'(req.action))
            ACT_LOOKUP, ACT_DELETE, ACT_READ: state_d = ST_SCAN;
            ACT_PACKET: begin
              if (req.ip_addr != '0 && req.target_ip == own_ip_q) begin
                state_d = ST_SCAN;
              end else begin
                state_d = ST_FINISH;
              end
            end
            default: state_d = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (rd_vld_q && rd_idx_q == LAST_IDX) begin
          state_d = ST_AGE;
        end
      end
      ST_AGE:    state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    act_d       = act_q;
    ip_d        = ip_q;
    tgt_d       = tgt_q;
    mac_d       = mac_q;
    op_d        = op_q;
    eidx_d      = eidx_q;
    valid_d     = valid_q;
    now_d       = now_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    free_fnd_d  = free_fnd_q;
    hit_idx_d   = hit_idx_q;
    hit_ip_d    = hit_ip_q;
    hit_mac_d   = hit_mac_q;
    hit_stamp_d = hit_stamp_q;
    free_idx_d  = free_idx_q;
    old_idx_d   = old_idx_q;
    old_stamp_d = old_stamp_q;
    age_d       = age_q;
    out_vld_d   = out_vld_q && !rsp.ready;
    status_d    = status_q;
    ipo_d       = ipo_q;
    maco_d      = maco_q;
    ageo_d      = ageo_q;
    reply_d     = reply_q;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = lrn_idx;
    st_wdata    = '{ip: ip_q, mac: mac_q, stamp: now_q};

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          act_d      = action_e'(req.action);
          ip_d       = req.ip_addr;
          tgt_d      = req.target_ip;
          mac_d      = req.mac_addr;
          op_d       = req.arp_opcode;
          eidx_d     = req.entry_index;
          scan_d     = '0;
          cnt_d      = '0;
          hit_d      = 1'b0;
          free_fnd_d = 1'b0;
        end
      end
      ST_SCAN: begin
        // issue one read per cycle, examine the one issued last cycle
        if (scan_q != SCAN_END) begin
          st_re    = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IW-1:0];
          scan_d   = scan_q + 1'b1;
        end
        if (rd_vld_q) begin
          if (sel_hit && !hit_q) begin
            hit_d       = 1'b1;
            hit_idx_d   = rd_idx_q;
            hit_ip_d    = st_rdata.ip;
            hit_mac_d   = st_rdata.mac;
            hit_stamp_d = st_rdata.stamp;
          end
          if (ent_v) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (!ent_v && !free_fnd_q) begin
            free_fnd_d = 1'b1;
            free_idx_d = rd_idx_q;
          end
          if (rd_idx_q == '0 || st_rdata.stamp < old_stamp_q) begin
            old_idx_d   = rd_idx_q;
            old_stamp_d = st_rdata.stamp;
          end
        end
      end
      ST_AGE: begin
        age_d = prod_w[31:0];
      end
      ST_FINISH: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          status_d  = 1'b0;
          ipo_d     = '0;
          maco_d    = '0;
          ageo_d    = '0;
          reply_d   = 1'b0;
          unique case (act_q)
            ACT_TICK:   now_d = now_q + 1'b1;
            ACT_LOOKUP: begin
              status_d = !found_w;
              if (found_w) begin
                maco_d = hit_mac_q;
              end
              if (expired_w) begin
                valid_d[hit_idx_q] = 1'b0;
              end
            end
            ACT_PACKET: begin
              if (learn_w) begin
                if (expired_w) begin
                  valid_d[hit_idx_q] = 1'b0;
                end
                valid_d[lrn_idx] = 1'b1;
                st_we = 1'b1;
              end
              if (op_q == OPC_REQUEST && own_ip_q != '0 && tgt_q == own_ip_q) begin
                reply_d = 1'b1;
                ipo_d   = ip_q;
                maco_d  = mac_q;
              end
            end
            ACT_DELETE: begin
              status_d = !found_w;
              if (hit_q) begin
                valid_d[hit_idx_q] = 1'b0;
              end
            end
            ACT_FLUSH:  valid_d = '0;
            ACT_READ: begin
              status_d = !hit_q;
              if (hit_q) begin
                ipo_d  = hit_ip_q;
                maco_d = hit_mac_q;
                ageo_d = age_q;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      valid_q    <= '0;
      now_q      <= '0;
      scan_q     <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      cnt_q      <= '0;
      hit_q      <= 1'b0;
      free_fnd_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      valid_q    <= valid_d;
      now_q      <= now_d;
      scan_q     <= scan_d;
      rd_vld_q   <= rd_vld_d;
      rd_idx_q   <= rd_idx_d;
      cnt_q      <= cnt_d;
      hit_q      <= hit_d;
      free_fnd_q <= free_fnd_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    ip_q        <= ip_d;
    tgt_q       <= tgt_d;
    mac_q       <= mac_d;
    op_q        <= op_d;
    eidx_q      <= eidx_d;
    hit_idx_q   <= hit_idx_d;
    hit_ip_q    <= hit_ip_d;
    hit_mac_q   <= hit_mac_d;
    hit_stamp_q <= hit_stamp_d;
    free_idx_q  <= free_idx_d;
    old_idx_q   <= old_idx_d;
    old_stamp_q <= old_stamp_d;
    age_q       <= age_d;
    status_q    <= status_d;
    ipo_q       <= ipo_d;
    maco_q      <= maco_d;
    ageo_q      <= ageo_d;
    reply_q     <= reply_d;
  end

  assign req.ready      = (state_q == ST_IDLE);
  assign rsp.valid      = out_vld_q;
  assign rsp.status     = status_q;
  assign rsp.ip_out     = ipo_q;
  assign rsp.mac_out    = maco_q;
  assign rsp.age_out    = ageo_q;
  assign rsp.send_reply = reply_q;

`ifndef SYNTHESIS
  a_rsp_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == ST_FINISH))
    else $error("result beat raised outside the finish step");

  a_read_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> state_q == ST_SCAN)
    else $error("slot read pending outside the scan");

  a_learn_sets_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && learn_w) |=> valid_q[$past(lrn_idx)])
    else $error("learned slot not marked valid");

  a_flush_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_go && act_q == ACT_FLUSH) |=> valid_q == '0)
    else $error("flush left a valid slot");
`endif

endmodule

`default_nettype wire

>>> verif/arpc_checker.sv
// ----------------------------------------------------------------------------
// ARP cache response checker
// Watches the request, response and register ports of the cache. Keeps its
// own copy of the slot array, time counter and registers, works out the
// response for every accepted request beat and compares each response beat
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module arpc_checker #(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  arpc_req_if                                 req,
  arpc_rsp_if                                 rsp,
  input  wire logic                           cfg_we_i,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                    cfg_wdata_i,
  output int unsigned                         n_failed_o,
  output int unsigned                         n_pending_o,
  output int unsigned                         n_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] ip;
    logic [31:0] tgt;
    logic [47:0] mac;
    logic [15:0] opc;
    logic [3:0]  idx;
  } arp_req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] age;
    logic        reply;
  } arp_rsp_t;

  logic        slot_vld  [ENTRIES];
  logic [31:0] slot_addr [ENTRIES];
  logic [47:0] slot_hw   [ENTRIES];
  logic [31:0] slot_born [ENTRIES];
  logic [31:0] tick_now;

  logic [31:0] own_addr;
  logic [31:0] ttl_lim;
  logic [9:0]  step_ms;

  arp_rsp_t pending_rsps[$];

  function automatic void clear_slots();
    for (int i = 0; i < ENTRIES; i++) begin
      slot_vld[i]  = 1'b0;
      slot_addr[i] = '0;
      slot_hw[i]   = '0;
      slot_born[i] = '0;
    end
  endfunction

  // Product wraps at 32 bits on purpose
  function automatic logic [31:0] age_ms(int i);
    logic [31:0] d;
    d = tick_now - slot_born[i];
    return d * {22'd0, step_ms};
  endfunction

  // First valid match; drop it and report a miss when it has outlived the TTL
  function automatic int find_live(logic [31:0] addr);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_vld[i] && slot_addr[i] == addr) begin
        if (age_ms(i) > ttl_lim) begin
          slot_vld[i] = 1'b0;
          return -1;
        end
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void learn_slot(logic [31:0] addr, logic [47:0] hw);
    int e;
    int oldest;
    e = find_live(addr);
    oldest = 0;
    if (e < 0) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_vld[i]) begin
          e = i;
          break;
        end
        if (slot_born[i] < slot_born[oldest]) oldest = i;
      end
      if (e < 0) e = oldest;
    end
    slot_addr[e] = addr;
    slot_hw[e]   = hw;
    slot_born[e] = tick_now;
    slot_vld[e]  = 1'b1;
  endfunction

  function automatic arp_rsp_t arp_predict(arp_req_t r);
    arp_rsp_t e;
    int hit;
    int unsigned seen;
    e = '0;
    case (r.action)
      ACT_TICK: tick_now = tick_now + 32'd1;
      ACT_LOOKUP: begin
        hit = find_live(r.ip);
        if (hit < 0) e.status = 1'b1;
        else e.mac = slot_hw[hit];
      end
      ACT_PACKET: begin
        if (r.ip != '0 && r.tgt == own_addr) learn_slot(r.ip, r.mac);
        if (r.opc == OPC_REQUEST && own_addr != '0 && r.tgt == own_addr) begin
          e.reply = 1'b1;
          e.ip    = r.ip;
          e.mac   = r.mac;
        end
      end
      ACT_DELETE: begin
        hit = find_live(r.ip);
        if (hit < 0) e.status = 1'b1;
        else slot_vld[hit] = 1'b0;
      end
      ACT_FLUSH: clear_slots();
      ACT_READ: begin
        // walk valid slots only; stale ones are reported, not expired
        e.status = 1'b1;
        seen = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_vld[i]) begin
            if (seen == r.idx && e.status) begin
              e.status = 1'b0;
              e.ip     = slot_addr[i];
              e.mac    = slot_hw[i];
              e.age    = age_ms(i);
            end
            seen++;
          end
        end
      end
      default: ;
    endcase
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    arp_req_t beat;
    arp_rsp_t want;
    logic     bad;
    if (!rst_ni) begin
      clear_slots();
      tick_now = '0;
      own_addr = '0;
      ttl_lim  = TTL_MS_RST;
      step_ms  = MS_PER_TICK_RST;
      pending_rsps.delete();
      n_failed_o  = 0;
      n_checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_OWN_IP:      own_addr = cfg_wdata_i;
          CFG_TTL_MS:      ttl_lim  = cfg_wdata_i;
          CFG_MS_PER_TICK: step_ms  = cfg_wdata_i[9:0];
          default: ;
        endcase
      end

      // retire before predicting: a response beat never belongs to this edge's request
      if (rsp.valid && rsp.ready) begin
        n_checked_o++;
        if (pending_rsps.size() == 0) begin
          if (n_failed_o < 10)
            $display("[%0t] response beat with nothing outstanding: %s",
                     $realtime, $sformatf("st=%0b ip=%h mac=%h age=%h rep=%0b",
                     rsp.status, rsp.ip_out, rsp.mac_out, rsp.age_out,
                     rsp.send_reply));
          n_failed_o++;
        end else begin
          want = pending_rsps.pop_front();
          bad = (rsp.status !== want.status) || (rsp.ip_out !== want.ip) ||
                (rsp.mac_out !== want.mac) || (rsp.age_out !== want.age) ||
                (rsp.send_reply !== want.reply);
          if (bad) begin
            if (n_failed_o < 10) begin
              $display("[%0t] response mismatch", $realtime);
              $display("  want st=%0b ip=%h mac=%h age=%h rep=%0b",
                       want.status, want.ip, want.mac, want.age, want.reply);
              $display("  got  st=%0b ip=%h mac=%h age=%h rep=%0b",
                       rsp.status, rsp.ip_out, rsp.mac_out, rsp.age_out, rsp.send_reply);
            end
            n_failed_o++;
          end
        end
      end

      if (req.valid && req.ready) begin
        beat = '{action: req.action, ip: req.ip_addr, tgt: req.target_ip,
                 mac: req.mac_addr, opc: req.arp_opcode, idx: req.entry_index};
        pending_rsps.push_back(arp_predict(beat));
      end
    end
    n_pending_o = pending_rsps.size();
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// ARP cache testbench
// Drives request beats and register writes into the cache, applies random
// backpressure on responses and leaves all checking to arpc_checker. A short
// directed sequence covers learning, replies, expiry, delete, flush, read and
// the spare actions; random phases then run under several register settings
// and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arpc_pkg::*;

  localparam int unsigned ENTRIES     = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned PHASE_BEATS = 160;
  localparam int unsigned POOL_SIZE   = 20;

  localparam logic [2:0]  ACT_SPARE_LO = 3'd6;
  localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
  localparam logic [15:0] OPC_REPLY    = 16'd2;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [31:0]          cfg_wdata;

  int unsigned n_failed;
  int unsigned n_pending;
  int unsigned n_checked;
  int unsigned cycle_cnt;

  int unsigned snd_idle;
  int unsigned rcv_stall;
  logic [31:0] host_ip;
  logic [31:0] peer_pool [POOL_SIZE];
  int unsigned beats_by_act [8];

  arpc_req_if req_ch ();
  arpc_rsp_if rsp_ch ();

  arp_cache_with_aging_core #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  arpc_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .n_failed_o (n_failed),
    .n_pending_o(n_pending),
    .n_checked_o(n_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk_i);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d responses outstanding", cycle_cnt, n_pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Response backpressure
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_ch.ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  task automatic send_beat(input logic [2:0] act, input logic [31:0] ip,
                           input logic [31:0] tgt, input logic [47:0] mac,
                           input logic [15:0] opc, input logic [3:0] idx);
    while ($urandom_range(99) < snd_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.ip_addr     <= ip;
    req_ch.target_ip   <= tgt;
    req_ch.mac_addr    <= mac;
    req_ch.arp_opcode  <= opc;
    req_ch.entry_index <= idx;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    beats_by_act[act]++;
  endtask

  // Drop valid, wait out every outstanding response, then hold a while longer
  task automatic drain(input int unsigned hold);
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (n_pending != 0) @(negedge clk_i);
    repeat (hold + 1) @(posedge clk_i);
  endtask

  task automatic program_cfg(input logic [31:0] own, input logic [31:0] ttl,
                             input logic [31:0] mpt_word);
    drain(ENTRIES + 8);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_OWN_IP;
    cfg_wdata <= own;
    @(posedge clk_i);
    cfg_idx   <= CFG_TTL_MS;
    cfg_wdata <= ttl;
    @(posedge clk_i);
    cfg_idx   <= CFG_MS_PER_TICK;
    cfg_wdata <= mpt_word;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    host_ip = own;
  endtask

  task automatic rand_beat();
    int unsigned pick;
    logic [2:0]  act;
    logic [31:0] ip;
    logic [31:0] tgt;
    logic [15:0] opc;
    pick = $urandom_range(99);
    if (pick < 18)      act = ACT_TICK;
    else if (pick < 38) act = ACT_LOOKUP;
    else if (pick < 68) act = ACT_PACKET;
    else if (pick < 76) act = ACT_DELETE;
    else if (pick < 78) act = ACT_FLUSH;
    else if (pick < 94) act = ACT_READ;
    else                act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;

    // mostly a small address pool so the table fills, hits and evicts
    pick = $urandom_range(99);
    if (pick < 85)      ip = peer_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 88) ip = '0;
    else                ip = $urandom();

    pick = $urandom_range(99);
    if (pick < 80)      tgt = host_ip;
    else if (pick < 88) tgt = '0;
    else                tgt = $urandom();

    pick = $urandom_range(99);
    if (pick < 45)      opc = OPC_REQUEST;
    else if (pick < 80) opc = OPC_REPLY;
    else                opc = 16'($urandom());

    send_beat(act, ip, tgt, {16'($urandom()), 32'($urandom())}, opc,
              4'($urandom_range(15)));
  endtask

  task automatic run_phase(input int unsigned snd, input int unsigned rcv,
                           input bit squeeze);
    snd_idle  = snd;
    rcv_stall = rcv;
    for (int unsigned i = 0; i < PHASE_BEATS; i++) begin
      if (squeeze && i == PHASE_BEATS / 2) drain(0);
      rand_beat();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    snd_idle  = 0;
    rcv_stall = 0;
    host_ip   = '0;
    foreach (beats_by_act[a]) beats_by_act[a] = 0;
    foreach (peer_pool[p]) peer_pool[p] = $urandom();
    peer_pool[0] = 32'hFFFF_FFFF;
    peer_pool[1] = 32'h0000_0001;

    req_ch.valid       <= 1'b0;
    req_ch.action      <= ACT_TICK;
    req_ch.ip_addr     <= '0;
    req_ch.target_ip   <= '0;
    req_ch.mac_addr    <= '0;
    req_ch.arp_opcode  <= '0;
    req_ch.entry_index <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_OWN_IP;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values: own IP unconfigured, 120 s TTL, 10 ms per tick
    send_beat(ACT_READ,   32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_LOOKUP, 32'h0A00_0001, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_PACKET, 32'h0A00_0001, 32'h0, 48'hFFFF_FFFF_FFFF, OPC_REQUEST, 4'd0);
    send_beat(ACT_PACKET, 32'h0, 32'h0, 48'h1234_5678_9ABC, OPC_REQUEST, 4'd0);
    send_beat(ACT_LOOKUP, 32'h0A00_0001, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_TICK,   32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_READ,   32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_READ,   32'h0, 32'h0, 48'h0, 16'h0, 4'd15);
    send_beat(ACT_DELETE, 32'h0A00_0001, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_DELETE, 32'h0A00_0001, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 4'd15);
    send_beat(ACT_SPARE_HI, 32'h0, 32'h0, 48'h0, 16'h0, 4'd0);

    // Configured host, short TTL: three ticks push ages past it
    program_cfg(32'hC0A8_0001, 32'd25, 32'd10);
    send_beat(ACT_PACKET, 32'hFFFF_FFFF, host_ip, 48'hFFFF_FFFF_FFFF, OPC_REQUEST, 4'd0);
    send_beat(ACT_PACKET, 32'h0A00_0002, host_ip, 48'h0, OPC_REPLY, 4'd0);
    send_beat(ACT_PACKET, 32'h0A00_0003, host_ip, 48'h0000_0000_0001, 16'hFFFF, 4'd0);
    send_beat(ACT_PACKET, 32'h0A00_0004, 32'h0A00_00FF, 48'h5, OPC_REQUEST, 4'd0);
    send_beat(ACT_PACKET, 32'h0A00_0005, host_ip, 48'h6, 16'h0, 4'd0);
    repeat (3) send_beat(ACT_TICK, 32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_READ,   32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_DELETE, 32'h0A00_0003, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_FLUSH,  32'h0, 32'h0, 48'h0, 16'h0, 4'd0);
    send_beat(ACT_READ,   32'h0, 32'h0, 48'h0, 16'h0, 4'd0);

    program_cfg($urandom(), 32'd400, 32'd10);
    run_phase(0, 0, 1'b0);
    program_cfg(32'hFFFF_FFFF, 32'd0, 32'd1000);
    run_phase(70, 0, 1'b1);
    program_cfg($urandom(), 32'hFFFF_FFFF, 32'd1);
    run_phase(0, 70, 1'b0);
    // upper data bits set; the register keeps zero, so every age reads zero
    program_cfg(32'h0, 32'd5, 32'hFFFF_FC00);
    run_phase(24, 24, 1'b0);
    program_cfg($urandom(), 32'd3000, 32'h0000_03FF);
    run_phase(0, 0, 1'b0);

    drain(ENTRIES + 8);
    $display("Sent %0d tick, %0d lookup, %0d packet, %0d delete, %0d flush,",
             beats_by_act[ACT_TICK], beats_by_act[ACT_LOOKUP], beats_by_act[ACT_PACKET],
             beats_by_act[ACT_DELETE], beats_by_act[ACT_FLUSH]);
    $display("  %0d read and %0d spare beats; compared %0d responses over seven",
             beats_by_act[ACT_READ],
             beats_by_act[ACT_SPARE_LO] + beats_by_act[ACT_SPARE_HI], n_checked);
    $display("  register settings (TTL 0 to all-ones, 0 to 1023 ms/tick)");
    if (n_failed == 0 && n_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_req_if.sv
hw/rtl/arpc_rsp_if.sv
hw/rtl/arpc_store.sv
hw/rtl/arp_cache_with_aging_core.sv
verif/arpc_checker.sv
verif/tb_top.sv
